// ----- hdl/assert_macros.svh -----
// Assertion macros used by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an implication holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gdn_pkg.sv -----
// ----------------------------------------------------------------------------
// gdn_pkg
// Types and constants shared by the day-number controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gdn_pkg;

    localparam logic [2:0] ACT_LOAD = 3'd0;
    localparam logic [2:0] ACT_ADD  = 3'd1;
    localparam logic [2:0] ACT_INC  = 3'd2;
    localparam logic [2:0] ACT_DEC  = 3'd3;
    localparam logic [2:0] ACT_CMP  = 3'd4;

    localparam logic [1:0] ORD_EQUAL   = 2'd0;
    localparam logic [1:0] ORD_LATER   = 2'd1;
    localparam logic [1:0] ORD_EARLIER = 2'd2;

    localparam int DAYS_400 = 146097;
    localparam int DAYS_100 = 36524;
    localparam int DAYS_4   = 1461;
    localparam int DAYS_1   = 365;

    // Controller commands to the datapath
    typedef struct packed {
        logic capture;   // latch the input transaction
        logic fwd_start; // start the date to number computation
        logic arith;     // compute the candidate number
        logic commit;    // write candidate and start back-conversion
        logic conv_step; // one step of the back-conversion
        logic finish;    // build the result register
    } gdn_cmd_t;

    // Datapath status to the controller
    typedef struct packed {
        logic fwd_done;
        logic store;     // candidate is to be stored
        logic conv_done;
    } gdn_sts_t;

    // Cumulative days before each month, non-leap
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        begin
            unique case (m)
                4'd1:    r = 9'd0;
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // Month length, index 0 is January
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
        logic [4:0] r;
        begin
            unique case (m)
                4'd1:                        r = lp ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10:     r = 5'd30;
                default:                     r = 5'd31;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gdn_datapath.sv -----
// ----------------------------------------------------------------------------
// gdn_datapath
// Stored date, date to number conversion, offset arithmetic and the
// step-by-step conversion of a day number back to day, month and year.
// ----------------------------------------------------------------------------
`default_nettype none

module gdn_datapath #(
    parameter int MAX_YEAR = 9999,
    parameter int MAX_DAYS = 3652059
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  gdn_pkg::gdn_cmd_t    cmd,
    output gdn_pkg::gdn_sts_t    sts,
    input  wire  [2:0]           action,
    input  wire  [4:0]           day_in,
    input  wire  [3:0]           month_in,
    input  wire  [13:0]          year_in,
    input  wire  signed [21:0]   offset,
    output logic [21:0]          day_number,
    output logic [4:0]           day_out,
    output logic [3:0]           month_out,
    output logic [13:0]          year_out,
    output logic                 leap,
    output logic [1:0]           order,
    output logic                 error
);
    import gdn_pkg::*;

    localparam int NW = 26;  // number width with headroom for sums
    localparam int YW = 17;

    // Divide by 100 through a reciprocal multiply, exact below 43699
    function automatic logic [YW-1:0] div100(input logic [YW-1:0] v);
        logic [YW+12:0] prod;
        prod = (YW+13)'(v) * (YW+13)'(5243);
        return YW'(prod[YW+12:19]);
    endfunction

    function automatic logic is_leap(input logic [YW-1:0] y);
        logic [YW-1:0] q;
        logic [YW-1:0] rem;
        q   = div100(y);
        rem = y - q * YW'(100);
        // A century year is leap only when its century count is a multiple of four
        return (rem != '0) ? (y[1:0] == 2'd0) : (q[1:0] == 2'd0);
    endfunction

    // Captured transaction
    logic [2:0]            act_reg;
    logic [4:0]            d_reg;
    logic [3:0]            m_reg;
    logic [YW-1:0]         y_reg;
    logic signed [21:0]    off_reg;

    // Stored date
    logic [NW-1:0]         num_reg;
    logic [4:0]            sday_reg;
    logic [3:0]            smon_reg;
    logic [13:0]           syear_reg;

    // Forward conversion: accumulate days of whole years over several steps
    logic [YW-1:0]         fp_reg;    // years remaining to count, y-1
    logic [NW-1:0]         fn_reg;    // accumulated days
    logic [1:0]            fph_reg;   // phase: 0 p*365, 1 p/4, 2 p/100, 3 p/400
    logic                  fdone_reg;
    logic                  yleap_reg; // input year is a leap year

    logic signed [NW:0]    cand_reg;
    logic                  store_reg;
    logic                  err_reg;
    logic [1:0]            ord_reg;

    // Back-conversion
    logic [NW-1:0]         r_reg;
    logic [YW-1:0]         yacc_reg;
    logic [2:0]            cph_reg;   // 0 400s, 1 100s, 2 4s, 3 1s, 4 months
    logic [2:0]            cnt_reg;
    logic [3:0]            mi_reg;
    logic                  cdone_reg;
    logic                  cleap_reg; // converted year is a leap year

    logic                  bad_in;
    logic [NW-1:0]         fwd_total;
    logic signed [NW:0]    arith_n;
    logic                  in_rng;

    assign bad_in = (m_reg == 4'd0) || (m_reg > 4'd12) || (y_reg > YW'(MAX_YEAR));

    // Forward number: year sum plus days before the month, leap day and day
    assign fwd_total = fn_reg + NW'(month_start(m_reg))
                     + NW'((m_reg > 4'd2) && yleap_reg) + NW'(d_reg);

    always_comb
    begin
        unique case (act_reg)
            ACT_ADD: arith_n = $signed({1'b0, num_reg}) + (NW+1)'(off_reg);
            ACT_INC: arith_n = $signed({1'b0, num_reg}) + (NW+1)'(1);
            ACT_DEC: arith_n = $signed({1'b0, num_reg}) - (NW+1)'(1);
            default: arith_n = $signed({1'b0, fwd_total});
        endcase
    end

    assign in_rng = (arith_n >= (NW+1)'(1)) && (arith_n <= (NW+1)'(MAX_DAYS));

    assign sts.fwd_done  = fdone_reg;
    assign sts.store     = store_reg;
    assign sts.conv_done = cdone_reg;

    // Capture the transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            d_reg   <= day_in;
            m_reg   <= month_in;
            y_reg   <= YW'(year_in);
            off_reg <= offset;
        end
    end

    // Forward whole-year sum, one term per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg    <= '0;
            fn_reg    <= '0;
            yleap_reg <= 1'b0;
            fdone_reg <= 1'b0;
            fph_reg   <= 2'd0;
        end
        else if (cmd.fwd_start)
        begin
            fp_reg    <= (y_reg == '0) ? '0 : y_reg - YW'(1);
            fn_reg    <= '0;
            yleap_reg <= is_leap(y_reg);
            fph_reg   <= 2'd0;
            fdone_reg <= 1'b0;
        end
        else if (!fdone_reg)
        begin
            unique case (fph_reg)
                2'd0: fn_reg <= fn_reg + NW'(fp_reg) * NW'(365);
                2'd1: fn_reg <= fn_reg + NW'(fp_reg >> 2);
                2'd2: fn_reg <= fn_reg - NW'(div100(fp_reg));
                default: fn_reg <= fn_reg + NW'(div100(fp_reg) >> 2);
            endcase
            fph_reg <= fph_reg + 2'd1;
            if (fph_reg == 2'd3)
                fdone_reg <= 1'b1;
        end
    end

    // Candidate, error and order
    always_ff @(posedge clk)
    begin
        if (cmd.arith)
        begin
            cand_reg  <= arith_n;
            ord_reg   <= ORD_EQUAL;
            store_reg <= 1'b0;
            err_reg   <= 1'b0;
            if (act_reg > ACT_CMP)
                err_reg <= 1'b1;
            else if (((act_reg == ACT_LOAD) || (act_reg == ACT_CMP)) && bad_in)
                err_reg <= 1'b1;
            else if (!in_rng)
                err_reg <= 1'b1;
            else if (act_reg == ACT_CMP)
            begin
                if (num_reg > NW'(arith_n))
                    ord_reg <= ORD_LATER;
                else if (num_reg < NW'(arith_n))
                    ord_reg <= ORD_EARLIER;
            end
            else
                store_reg <= 1'b1;
        end
    end

    // Back-conversion by repeated subtraction, one unit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg     <= '0;
            yacc_reg  <= '0;
            cnt_reg   <= 3'd0;
            mi_reg    <= 4'd0;
            cleap_reg <= 1'b0;
            cdone_reg <= 1'b0;
            cph_reg   <= 3'd0;
        end
        else if (cmd.commit)
        begin
            r_reg     <= NW'(cand_reg) - NW'(1);
            yacc_reg  <= YW'(1);
            cph_reg   <= 3'd0;
            cnt_reg   <= 3'd0;
            mi_reg    <= 4'd0;
            cdone_reg <= 1'b0;
        end
        else if (cmd.conv_step && !cdone_reg)
        begin
            unique case (cph_reg)
                3'd0:
                begin
                    if (r_reg >= NW'(DAYS_400))
                    begin
                        r_reg    <= r_reg - NW'(DAYS_400);
                        yacc_reg <= yacc_reg + YW'(400);
                    end
                    else
                        cph_reg <= 3'd1;
                end
                3'd1:
                begin
                    if (r_reg >= NW'(DAYS_100) && cnt_reg < 3'd3)
                    begin
                        r_reg    <= r_reg - NW'(DAYS_100);
                        yacc_reg <= yacc_reg + YW'(100);
                        cnt_reg  <= cnt_reg + 3'd1;
                    end
                    else
                    begin
                        cph_reg <= 3'd2;
                        cnt_reg <= 3'd0;
                    end
                end
                3'd2:
                begin
                    if (r_reg >= NW'(DAYS_4))
                    begin
                        r_reg    <= r_reg - NW'(DAYS_4);
                        yacc_reg <= yacc_reg + YW'(4);
                    end
                    else
                        cph_reg <= 3'd3;
                end
                3'd3:
                begin
                    if (r_reg >= NW'(DAYS_1) && cnt_reg < 3'd3)
                    begin
                        r_reg    <= r_reg - NW'(DAYS_1);
                        yacc_reg <= yacc_reg + YW'(1);
                        cnt_reg  <= cnt_reg + 3'd1;
                    end
                    else
                    begin
                        cph_reg   <= 3'd4;
                        cleap_reg <= is_leap(yacc_reg);
                    end
                end
                default:
                begin
                    if (mi_reg < 4'd11
                        && r_reg >= NW'(month_len(mi_reg, cleap_reg)))
                    begin
                        r_reg  <= r_reg - NW'(month_len(mi_reg, cleap_reg));
                        mi_reg <= mi_reg + 4'd1;
                    end
                    else
                        cdone_reg <= 1'b1;
                end
            endcase
        end
    end

    // Stored date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg   <= '0;
            sday_reg  <= '0;
            smon_reg  <= '0;
            syear_reg <= '0;
        end
        else if (cmd.commit)
            num_reg <= NW'(cand_reg);
        else if (cmd.conv_step && cdone_reg)
        begin
            sday_reg  <= 5'(r_reg + NW'(1));
            smon_reg  <= mi_reg + 4'd1;
            syear_reg <= 14'(yacc_reg);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            day_number <= num_reg[21:0];
            day_out    <= sday_reg;
            month_out  <= smon_reg;
            year_out   <= syear_reg;
            leap       <= (syear_reg != '0) && is_leap(YW'(syear_reg));
            order      <= ord_reg;
            error      <= err_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gdn_ctrl.sv -----
// ----------------------------------------------------------------------------
// gdn_ctrl
// Sequencer for one transaction: capture, forward sum, check, convert back
// when a date is stored, then hold the result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gdn_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output gdn_pkg::gdn_cmd_t    cmd,
    input  gdn_pkg::gdn_sts_t    sts
);
    import gdn_pkg::*;

    `include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FWD0  = 3'd1;
    localparam logic [2:0] ST_FWD   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DEC   = 3'd4;
    localparam logic [2:0] ST_CONV  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = s_tvalid;
                if (s_tvalid)
                    state_next = ST_FWD0;
            end
            ST_FWD0:
            begin
                cmd.fwd_start = 1'b1;
                state_next    = ST_FWD;
            end
            ST_FWD:
                if (sts.fwd_done)
                    state_next = ST_CHECK;
            ST_CHECK:
            begin
                cmd.arith  = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.commit = sts.store;
                state_next = sts.store ? ST_CONV : ST_FIN;
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (sts.conv_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            default:
                if (m_tready)
                    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `ASSERT_IMPL(a_excl, clk, rst_n, 1'b1, !(s_tready && m_tvalid), "ready while result pending")
    `ASSERT_NEXT(a_cap, clk, rst_n, s_tvalid && s_tready, state_reg == ST_FWD0, "capture lost")
    `ASSERT_NEXT(a_done, clk, rst_n, m_tvalid && m_tready, s_tready, "no return to idle")

endmodule

`default_nettype wire

// ----- hdl/gregorian_day_number_unit_top.sv -----
// ----------------------------------------------------------------------------
// gregorian_day_number_unit_top
// Holds one Gregorian date as a day number; loads, offsets, steps and
// compares it, returning the date converted back on every transaction.
//
// Channel  Dir  Contents
// s_axis   in   command: action, date fields, offset
// m_axis   out  stored date, leap flag, compare outcome, error
//
// One transaction at a time. When nothing is stored, the result becomes valid
// after a start step, the year sum, a check, a decision and the building
// of the result. Storing a date adds the back-conversion: with the default
// parameters up to 24 four-century, 3 century, 24 four-year, 3 year and 11
// month steps plus six phase steps. Reset clears the stored date to zero.
// A result holds on m_axis until taken; the next transaction is accepted in
// the cycle after it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_day_number_unit_top #(
    parameter int MAX_YEAR = 9999,
    parameter int MAX_DAYS = 3652059
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], day_in[7:3], month_in[11:8], year_in[25:12], offset[47:26]
    input  wire  [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // day_number[21:0], day_out[26:22], month_out[30:27], year_out[44:31],
    // leap[45], order[47:46], error[48]
    output logic [55:0] m_axis_tdata
);
    import gdn_pkg::*;

    gdn_cmd_t cmd;
    gdn_sts_t sts;

    logic [21:0] day_number;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
    logic        leap;
    logic [1:0]  order;
    logic        error;

    gdn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    gdn_datapath #(
        .MAX_YEAR (MAX_YEAR),
        .MAX_DAYS (MAX_DAYS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .action     (s_axis_tdata[2:0]),
        .day_in     (s_axis_tdata[7:3]),
        .month_in   (s_axis_tdata[11:8]),
        .year_in    (s_axis_tdata[25:12]),
        .offset     (s_axis_tdata[47:26]),
        .day_number (day_number),
        .day_out    (day_out),
        .month_out  (month_out),
        .year_out   (year_out),
        .leap       (leap),
        .order      (order),
        .error      (error)
    );

    assign m_axis_tdata = {7'd0, error, order, leap, year_out, month_out, day_out, day_number};

endmodule

`default_nettype wire
